[rtl/s2m_pkg.sv]
// Shared types and constants for the sensor-to-mouse motion block.
package s2m_pkg;

  localparam int VOLT_W      = 12;
  localparam int GAIN_W      = 8;
  localparam int SCALED_W    = 15;
  localparam int DIFF_W      = 17;
  localparam int RAMP_W      = 16;
  localparam int SENS_W      = 16;
  localparam int ACC_W       = 48;
  localparam int FRAC_W      = 24;
  localparam int OFFS_W      = 13;
  localparam int SUM_W       = 15;
  localparam int CAL_SAMPLES = 8;
  localparam int CAL_SHIFT   = $clog2(CAL_SAMPLES);
  localparam int CNT_W       = $clog2(CAL_SAMPLES);
  localparam int MUL_A_W     = 32;
  localparam int MUL_B_W     = 21;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // divide by 50: multiply by ceil(2^26 / 50), exact for products below 2^20
  localparam logic [MUL_B_W-1:0] RECIP_50    = 21'd1342178;
  localparam int                 RECIP_SHIFT = 26;
  // velocity factor 2e-7 in Q40
  localparam logic [17:0]        FACTOR      = 18'd219902;
  localparam logic [RAMP_W-1:0]  RAMP_LIMIT  = 16'd14600;
  localparam logic [6:0]         WHOLE_MAX   = 7'd127;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DZ_H   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DZ_V   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SENS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 3'd6;

  localparam logic [1:0] ORIENT_90  = 2'd1;
  localparam logic [1:0] ORIENT_180 = 2'd2;
  localparam logic [1:0] ORIENT_270 = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_GMUL, OP_GDIV, OP_GSTORE, OP_DIFF, OP_RAMP,
    OP_PRAMP, OP_PHI, OP_PLO, OP_CLAMP, OP_ACC, OP_WHOLE, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] lane;
    logic       axis;
  } cmd_t;

  typedef struct packed {
    logic nonzero;
    logic out_busy;
  } stat_t;

endpackage

[rtl/sensor_to_mouse_motion.sv]
// Top level: four sensor voltages in, relative mouse movement counts out.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+---------------------------------------
//   input    | in_valid / in_ready     | mode, volt_up/down/left/right
//   output   | out_valid / out_ready   | move_horiz, move_vert
//   config   | cfg_write (no wait)     | cfg_index, cfg_data
//
// A calibration request is handled in the idle state. A motion request waits for
// the output register if needed; one shared 32x21 multiplier runs twelve
// gain steps, then six steps per axis, one product per cycle.
// Synchronous reset restores configuration defaults and clears offsets, ramps,
// accumulators and sums.
// A new request is taken while a result waits; a second result stalls until
// the first is taken.
module sensor_to_mouse_motion (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           mode,
  input  logic [s2m_pkg::VOLT_W-1:0]     volt_up,
  input  logic [s2m_pkg::VOLT_W-1:0]     volt_down,
  input  logic [s2m_pkg::VOLT_W-1:0]     volt_left,
  input  logic [s2m_pkg::VOLT_W-1:0]     volt_right,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [7:0]              move_horiz,
  output logic signed [7:0]              move_vert,
  input  logic                           cfg_write,
  input  logic [s2m_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [s2m_pkg::CFG_DATA_W-1:0] cfg_data
);
  import s2m_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  s2m_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  s2m_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mode       (mode),
    .volt_up    (volt_up),
    .volt_down  (volt_down),
    .volt_left  (volt_left),
    .volt_right (volt_right),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .move_horiz (move_horiz),
    .move_vert  (move_vert)
  );

endmodule

[rtl/s2m_ctrl.sv]
// Sequencer that steps the shared multiplier datapath through one request.
module s2m_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          mode,
  output logic          in_ready,
  input  s2m_pkg::stat_t stat,
  output s2m_pkg::cmd_t  cmd
);
  import s2m_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_GMUL, S_GDIV, S_GST, S_DIFF, S_RAMP, S_PRAMP, S_PHI, S_PLO,
    S_CLAMP, S_ACC, S_WHOLE, S_EMIT
  } state_t;

  state_t     state;
  logic [1:0] lane;
  logic       axis;
  logic       emit_ok;

  assign in_ready = (state == S_IDLE);
  assign emit_ok  = !(stat.nonzero && stat.out_busy);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lane  <= 2'd0;
      axis  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          lane <= 2'd0;
          axis <= 1'b0;
          if (in_valid && !mode) state <= S_GMUL;
        end
        S_GMUL: state <= S_GDIV;
        S_GDIV: state <= S_GST;
        S_GST: begin
          lane  <= lane + 2'd1;
          state <= (lane == 2'd3) ? S_DIFF : S_GMUL;
        end
        S_DIFF:  state <= S_RAMP;
        S_RAMP:  state <= S_PRAMP;
        S_PRAMP: state <= S_PHI;
        S_PHI:   state <= S_PLO;
        S_PLO:   state <= S_CLAMP;
        S_CLAMP: state <= S_ACC;
        S_ACC: begin
          axis  <= 1'b1;
          state <= axis ? S_WHOLE : S_RAMP;
        end
        S_WHOLE: state <= S_EMIT;
        S_EMIT: begin
          // hold until the output register can take the result
          if (emit_ok) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.lane = lane;
    cmd.axis = axis;
    case (state)
      S_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_GMUL:  cmd.op = OP_GMUL;
      S_GDIV:  cmd.op = OP_GDIV;
      S_GST:   cmd.op = OP_GSTORE;
      S_DIFF:  cmd.op = OP_DIFF;
      S_RAMP:  cmd.op = OP_RAMP;
      S_PRAMP: cmd.op = OP_PRAMP;
      S_PHI:   cmd.op = OP_PHI;
      S_PLO:   cmd.op = OP_PLO;
      S_CLAMP: cmd.op = OP_CLAMP;
      S_ACC:   cmd.op = OP_ACC;
      S_WHOLE: cmd.op = OP_WHOLE;
      S_EMIT:  cmd.op = emit_ok ? OP_EMIT : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

[rtl/s2m_dpath.sv]
// Datapath: config registers, shared multiplier, axis state and output register.
module s2m_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  s2m_pkg::cmd_t                       cmd,
  output s2m_pkg::stat_t                      stat,
  input  logic                                cfg_write,
  input  logic [s2m_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [s2m_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                mode,
  input  logic [s2m_pkg::VOLT_W-1:0]          volt_up,
  input  logic [s2m_pkg::VOLT_W-1:0]          volt_down,
  input  logic [s2m_pkg::VOLT_W-1:0]          volt_left,
  input  logic [s2m_pkg::VOLT_W-1:0]          volt_right,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [7:0]                   move_horiz,
  output logic signed [7:0]                   move_vert
);
  import s2m_pkg::*;

  // configuration
  logic [1:0]  orientation;
  logic [31:0] gain_word;
  logic [11:0] dz [2];
  logic [7:0]  accel_step;
  logic [31:0] sens_word;
  logic [7:0]  speed_limit;

  // item and axis state
  logic [VOLT_W-1:0]          vin [4];
  logic [SCALED_W-1:0]        gv [4];
  logic signed [DIFF_W-1:0]   dval [2];
  logic [RAMP_W-1:0]          ramp [2];
  logic signed [ACC_W-1:0]    acc [2];
  logic signed [OFFS_W-1:0]   offset [2];
  logic signed [7:0]          whole [2];
  logic [SUM_W-1:0]           cal_sums [4];
  logic [CNT_W-1:0]           cal_count;
  logic [PROD_W-1:0]          prod;
  logic [15:0]                plow;
  logic [49:0]                mhi;
  logic [31:0]                mag_q;

  logic [MUL_A_W-1:0]         mul_a;
  logic [MUL_B_W-1:0]         mul_b;
  logic [VOLT_W-1:0]          raw [4];
  logic [SUM_W-1:0]           sum_next [4];
  logic signed [DIFF_W-1:0]   diff [2];
  logic signed [DIFF_W-1:0]   dz_out [2];
  logic signed [DIFF_W-1:0]   dneg;
  logic [15:0]                mag_d;
  logic [SENS_W-1:0]          sens_sel;
  logic [50:0]                msum;
  logic [31:0]                lim;
  logic signed [ACC_W:0]      acc_sum;
  logic signed [ACC_W:0]      step_val;
  logic signed [ACC_W-1:0]    acc_sat;
  logic [ACC_W:0]             absa [2];
  logic [ACC_W-FRAC_W:0]      ipart [2];
  logic [6:0]                 wmag [2];
  logic signed [7:0]          wval [2];

  assign raw[0] = volt_up;
  assign raw[1] = volt_down;
  assign raw[2] = volt_left;
  assign raw[3] = volt_right;

  assign stat.nonzero  = (whole[0] != 8'sd0) || (whole[1] != 8'sd0);
  assign stat.out_busy = out_valid && !out_ready;

  // operand select for the shared multiplier
  always_comb begin
    dneg     = -dval[cmd.axis];
    mag_d    = dval[cmd.axis][DIFF_W-1] ? dneg[15:0] : dval[cmd.axis][15:0];
    sens_sel = cmd.axis ? sens_word[31:16] : sens_word[15:0];
    case (cmd.op)
      OP_GMUL: begin
        mul_a = {20'd0, vin[cmd.lane]};
        mul_b = {13'd0, gain_word[8*cmd.lane +: 8]};
      end
      OP_GDIV: begin
        mul_a = {12'd0, prod[19:0]};
        mul_b = RECIP_50;
      end
      OP_RAMP: begin
        mul_a = {16'd0, mag_d};
        mul_b = {5'd0, sens_sel};
      end
      OP_PRAMP: begin
        mul_a = prod[31:0];
        mul_b = {5'd0, ramp[cmd.axis]};
      end
      OP_PHI: begin
        mul_a = prod[47:16];
        mul_b = {3'd0, FACTOR};
      end
      OP_PLO: begin
        mul_a = {16'd0, plow};
        mul_b = {3'd0, FACTOR};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // calibration sums
  always_comb begin
    for (int i = 0; i < 4; i++) sum_next[i] = cal_sums[i] + SUM_W'(raw[i]);
  end

  // axis differences and deadzone
  always_comb begin
    diff[0] = $signed({2'b00, gv[2]}) - $signed({2'b00, gv[3]})
              - DIFF_W'(offset[0]);
    diff[1] = $signed({2'b00, gv[0]}) - $signed({2'b00, gv[1]})
              - DIFF_W'(offset[1]);
    for (int i = 0; i < 2; i++) begin
      if (diff[i] < -$signed({5'd0, dz[i]}))
        dz_out[i] = diff[i] + $signed({5'd0, dz[i]});
      else if (diff[i] > $signed({5'd0, dz[i]}))
        dz_out[i] = diff[i] - $signed({5'd0, dz[i]});
      else
        dz_out[i] = '0;
    end
  end

  // clamp and accumulate
  always_comb begin
    msum     = {1'b0, mhi} + 51'(prod[33:16]);
    lim      = {speed_limit, 24'd0};
    step_val = dval[cmd.axis][DIFF_W-1] ? -$signed({17'd0, mag_q})
                                        : $signed({17'd0, mag_q});
    acc_sum  = $signed({acc[cmd.axis][ACC_W-1], acc[cmd.axis]}) + step_val;
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
      acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    else
      acc_sat = acc_sum[ACC_W-1:0];
  end

  // whole counts, truncated toward zero
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      absa[i]  = acc[i][ACC_W-1] ? ((ACC_W+1)'(0) - {acc[i][ACC_W-1], acc[i]})
                                 : {1'b0, acc[i]};
      ipart[i] = absa[i][ACC_W:FRAC_W];
      wmag[i]  = (ipart[i] > (ACC_W-FRAC_W+1)'(WHOLE_MAX)) ? WHOLE_MAX : ipart[i][6:0];
      wval[i]  = acc[i][ACC_W-1] ? -$signed({1'b0, wmag[i]}) : $signed({1'b0, wmag[i]});
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      orientation <= '0;
      gain_word   <= 32'h3232_3232;
      dz[0]       <= '0;
      dz[1]       <= '0;
      accel_step  <= '0;
      sens_word   <= '0;
      speed_limit <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ORIENT: orientation <= cfg_data[1:0];
        CFG_GAIN:   gain_word   <= cfg_data;
        CFG_DZ_H:   dz[0]       <= cfg_data[11:0];
        CFG_DZ_V:   dz[1]       <= cfg_data[11:0];
        CFG_ACCEL:  accel_step  <= cfg_data[7:0];
        CFG_SENS:   sens_word   <= cfg_data;
        CFG_SPEED:  speed_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // payload pipeline registers
  always_ff @(posedge clk) begin
    prod <= {21'd0, mul_a} * {32'd0, mul_b};
    case (cmd.op)
      OP_LOAD: begin
        case (orientation)
          ORIENT_90: begin
            vin[0] <= volt_left;  vin[2] <= volt_down;
            vin[1] <= volt_right; vin[3] <= volt_up;
          end
          ORIENT_180: begin
            vin[0] <= volt_down;  vin[1] <= volt_up;
            vin[2] <= volt_right; vin[3] <= volt_left;
          end
          ORIENT_270: begin
            vin[0] <= volt_right; vin[3] <= volt_down;
            vin[1] <= volt_left;  vin[2] <= volt_up;
          end
          default: begin
            for (int i = 0; i < 4; i++) vin[i] <= raw[i];
          end
        endcase
      end
      OP_GSTORE: gv[cmd.lane] <= prod[RECIP_SHIFT +: SCALED_W];
      OP_DIFF: begin
        dval[0] <= dz_out[0];
        dval[1] <= dz_out[1];
      end
      OP_PHI:   plow  <= prod[15:0];
      OP_PLO:   mhi   <= prod[49:0];
      OP_CLAMP: mag_q <= (msum > 51'(lim)) ? lim : msum[31:0];
      default: ;
    endcase
  end

  // persistent state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        ramp[i]   <= '0;
        acc[i]    <= '0;
        offset[i] <= '0;
        whole[i]  <= '0;
      end
      for (int i = 0; i < 4; i++) cal_sums[i] <= '0;
      cal_count  <= '0;
      out_valid  <= 1'b0;
      move_horiz <= '0;
      move_vert  <= '0;
    end else begin
      if (cmd.op == OP_EMIT && stat.nonzero) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (cmd.op)
        OP_LOAD: begin
          if (mode) begin
            if (cal_count == CNT_W'(CAL_SAMPLES - 1)) begin
              offset[0] <= $signed({1'b0, sum_next[2][SUM_W-1:CAL_SHIFT]})
                           - $signed({1'b0, sum_next[3][SUM_W-1:CAL_SHIFT]});
              offset[1] <= $signed({1'b0, sum_next[0][SUM_W-1:CAL_SHIFT]})
                           - $signed({1'b0, sum_next[1][SUM_W-1:CAL_SHIFT]});
              for (int i = 0; i < 4; i++) cal_sums[i] <= '0;
              cal_count <= '0;
            end else begin
              for (int i = 0; i < 4; i++) cal_sums[i] <= sum_next[i];
              cal_count <= cal_count + CNT_W'(1);
            end
          end
        end
        OP_RAMP: begin
          if (dval[cmd.axis] == '0)
            ramp[cmd.axis] <= '0;
          else if (ramp[cmd.axis] < RAMP_LIMIT)
            ramp[cmd.axis] <= ramp[cmd.axis] + RAMP_W'(accel_step);
        end
        OP_ACC: acc[cmd.axis] <= acc_sat;
        OP_WHOLE: begin
          whole[0] <= wval[0];
          whole[1] <= wval[1];
        end
        OP_EMIT: begin
          if (stat.nonzero) begin
            for (int i = 0; i < 2; i++)
              acc[i] <= acc[i] - $signed({{16{whole[i][7]}}, whole[i], 24'd0});
            move_horiz <= whole[0];
            move_vert  <= whole[1];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[tb/tb_sensor_to_mouse_motion.sv]
// Testbench for sensor_to_mouse_motion: directed and random requests checked by a scoreboard.
module tb_sensor_to_mouse_motion;
  import s2m_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam bit MODE_MOTION = 1'b0;
  localparam bit MODE_CAL    = 1'b1;
  localparam int SETTLE      = 64;

  typedef struct {
    logic signed [7:0] horiz;
    logic signed [7:0] vert;
  } move_t;

  class motion_scoreboard;
    bit [1:0]       orient;
    bit [31:0]      gains;
    int             dz_h, dz_v;
    bit [15:0]      accel;
    bit [31:0]      sens;
    bit [7:0]       speed;
    int             offs_h, offs_v;
    bit [15:0]      ramp_h, ramp_v;
    longint         acc_h, acc_v;
    bit [14:0]      sums[4];
    int             cal_cnt;
    move_t          moves_due[$];
    int             fail_count, result_count, cal_count_total, motion_total;

    function new();
      orient = 0; gains = 32'h3232_3232; dz_h = 0; dz_v = 0; accel = 0; sens = 0;
      speed = 0; offs_h = 0; offs_v = 0; ramp_h = 0; ramp_v = 0; acc_h = 0; acc_v = 0;
      foreach (sums[i]) sums[i] = 0;
      cal_cnt = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        CFG_ORIENT: orient = val[1:0];
        CFG_GAIN:   gains = val;
        CFG_DZ_H:   dz_h = val[11:0];
        CFG_DZ_V:   dz_v = val[11:0];
        CFG_ACCEL:  accel = val[7:0];
        CFG_SENS:   sens = val;
        CFG_SPEED:  speed = val[7:0];
        default: ;
      endcase
    endfunction

    function int deadzone(int v, int dz);
      if (v < -dz) return v + dz;
      if (v > dz) return v - dz;
      return 0;
    endfunction

    function bit [15:0] next_ramp(bit [15:0] r, int d);
      if (d == 0) return 0;
      if (r < RAMP_LIMIT) return r + accel;
      return r;
    endfunction

    function longint step_move(int d, longint unsigned s, bit [15:0] r);
      longint unsigned mag, p, m, lim;
      mag = d < 0 ? -d : d;
      p = mag * s * r;
      m = (p >> 16) * 64'(FACTOR) + (((p & 64'hFFFF) * 64'(FACTOR)) >> 16);
      lim = 64'(speed) << 24;
      if (m > lim) m = lim;
      return d < 0 ? -longint'(m) : longint'(m);
    endfunction

    function longint sat_add(longint a, longint m);
      longint s;
      s = a + m;
      if (s > 64'sh7FFF_FFFF_FFFF) s = 64'sh7FFF_FFFF_FFFF;
      if (s < -64'sh8000_0000_0000) s = -64'sh8000_0000_0000;
      return s;
    endfunction

    function int whole(longint a);
      longint w;
      w = a < 0 ? -((-a) >> 24) : a >> 24;
      if (w > 127) w = 127;
      if (w < -127) w = -127;
      return int'(w);
    endfunction

    function void note_request(bit m, int u, int dn, int l, int r);
      int t, x, y, wx, wy;
      move_t mv;
      if (m == MODE_CAL) begin
        cal_count_total++;
        sums[0] += u; sums[1] += dn; sums[2] += l; sums[3] += r;
        if (cal_cnt >= CAL_SAMPLES - 1) begin
          offs_h = int'(sums[2] >> 3) - int'(sums[3] >> 3);
          offs_v = int'(sums[0] >> 3) - int'(sums[1] >> 3);
          foreach (sums[i]) sums[i] = 0;
          cal_cnt = 0;
        end else begin
          cal_cnt++;
        end
        return;
      end
      motion_total++;
      case (orient)
        ORIENT_90:  begin t = u; u = l; l = dn; dn = r; r = t; end
        ORIENT_180: begin t = u; u = dn; dn = t; t = r; r = l; l = t; end
        ORIENT_270: begin t = u; u = r; r = dn; dn = l; l = t; end
        default: ;
      endcase
      u  = u  * int'(gains[7:0])   / 50;
      dn = dn * int'(gains[15:8])  / 50;
      l  = l  * int'(gains[23:16]) / 50;
      r  = r  * int'(gains[31:24]) / 50;
      x = deadzone(l - r - offs_h, dz_h);
      y = deadzone(u - dn - offs_v, dz_v);
      ramp_h = next_ramp(ramp_h, x);
      ramp_v = next_ramp(ramp_v, y);
      acc_h = sat_add(acc_h, step_move(x, sens[15:0], ramp_h));
      acc_v = sat_add(acc_v, step_move(y, sens[31:16], ramp_v));
      wx = whole(acc_h);
      wy = whole(acc_v);
      if (wx == 0 && wy == 0) return;
      acc_h -= longint'(wx) <<< 24;
      acc_v -= longint'(wy) <<< 24;
      mv.horiz = wx[7:0];
      mv.vert = wy[7:0];
      moves_due.push_back(mv);
    endfunction

    function void check_result(logic signed [7:0] h, logic signed [7:0] v);
      move_t mv;
      result_count++;
      if (moves_due.size() == 0) begin
        $error("unexpected result move_horiz %0d move_vert %0d", h, v);
        fail_count++;
        return;
      end
      mv = moves_due.pop_front();
      if (h !== mv.horiz) begin
        $error("move_horiz expected %0d actual %0d", mv.horiz, h);
        fail_count++;
      end
      if (v !== mv.vert) begin
        $error("move_vert expected %0d actual %0d", mv.vert, v);
        fail_count++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst;
  logic in_valid, in_ready, mode, out_valid, out_ready, cfg_write;
  logic [VOLT_W-1:0] volt_up, volt_down, volt_left, volt_right;
  logic signed [7:0] move_horiz, move_vert;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  motion_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int phases_run = 0;

  sensor_to_mouse_motion DUT (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(move_horiz, move_vert);
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #20000000;
    $display("sensor_to_mouse_motion: mismatch");
    $finish;
  end

  task automatic send_request(bit m, int u, int dn, int l, int r);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    volt_up <= VOLT_W'(u); volt_down <= VOLT_W'(dn);
    volt_left <= VOLT_W'(l); volt_right <= VOLT_W'(r);
    do @(posedge clk); while (!in_ready);
    sb.note_request(m, u, dn, l, r);
  endtask

  // hold until every expected result is seen, then let a request still in flight drain
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.moves_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(logic [31:0] vals[7]);
    foreach (vals[i]) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(CFG_IDX_W'(i), vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  function automatic int rand_volt();
    case ($urandom_range(3))
      0: return $urandom_range(4095);
      1: return $urandom_range(1) ? 4095 : 0;
      default: return $urandom_range(1800, 2300);
    endcase
  endfunction

  task automatic random_phase(int count);
    for (int k = 0; k < count; k++) begin
      case ((k / 40) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      if ($urandom_range(99) < 4) begin
        for (int j = 0; j < CAL_SAMPLES; j++)
          send_request(MODE_CAL, rand_volt(), rand_volt(), rand_volt(), rand_volt());
      end else begin
        send_request($urandom_range(99) < 3 ? MODE_CAL : MODE_MOTION,
                     rand_volt(), rand_volt(), rand_volt(), rand_volt());
      end
      // pause until every pending result is out
      if (k == count / 2) drain();
    end
    drain();
    phases_run++;
  endtask

  initial begin
    logic [31:0] regs[7];
    rst <= 1'b1;
    in_valid <= 1'b0; mode <= 1'b0; out_ready <= 1'b0;
    volt_up <= 0; volt_down <= 0; volt_left <= 0; volt_right <= 0;
    cfg_write <= 1'b0; cfg_index <= 0; cfg_data <= 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: unity gain, strong sensitivity, then extremes and calibration
    regs = '{ORIENT_90, 32'h3232_3232, 0, 0, 255, 32'h0800_0800, 255};
    write_regs(regs);
    send_request(MODE_MOTION, 0, 0, 0, 0);
    send_request(MODE_MOTION, 4095, 4095, 4095, 4095);
    send_request(MODE_MOTION, 4095, 0, 4095, 0);
    send_request(MODE_MOTION, 0, 4095, 0, 4095);
    send_request(MODE_MOTION, 4095, 0, 0, 4095);
    send_request(MODE_MOTION, 0, 4095, 4095, 0);
    for (int j = 0; j < CAL_SAMPLES; j++)
      send_request(MODE_CAL, j[0] ? 4095 : 0, 4095, 4095, j[1] ? 0 : 4095);
    send_request(MODE_MOTION, 2048, 2048, 2048, 2048);
    send_request(MODE_MOTION, 4095, 0, 4095, 0);
    drain();
    cfg_write <= 1'b1; cfg_index <= CFG_UNUSED; cfg_data <= '1;
    @(posedge clk);
    cfg_write <= 1'b0;
    for (int o = 0; o < 4; o++) begin
      regs = '{o, 32'hFFFF_FFFF, 4095, 4095, 255, 32'hFFFF_FFFF, 255};
      write_regs(regs);
      send_request(MODE_MOTION, 4095, 0, 4095, 0);
      send_request(MODE_MOTION, 0, 4095, 0, 4095);
      drain();
    end

    regs = '{3, 0, 0, 0, 0, 0, 0};
    write_regs(regs);
    random_phase(100);
    regs = '{0, 32'h3232_3232, 0, 0, 1, 32'h0040_0040, 255};
    write_regs(regs);
    random_phase(130);
    regs = '{2, 32'hFFFF_FFFF, 4095, 4095, 255, 32'hFFFF_FFFF, 255};
    write_regs(regs);
    random_phase(120);
    regs = '{1, 32'h3232_3232, 0, 0, 255, 32'h0800_0800, 1};
    write_regs(regs);
    random_phase(120);
    for (int p = 0; p < 5; p++) begin
      regs = '{$urandom_range(3), $urandom(), $urandom_range(600), $urandom_range(600),
               $urandom_range(255),
               {16'($urandom_range(4000)), 16'($urandom_range(4000))},
               $urandom_range(1, 255)};
      write_regs(regs);
      random_phase(120);
    end

    $display("ran %0d motion and %0d calibration requests over %0d phases,",
             sb.motion_total, sb.cal_count_total, phases_run);
    $display("%0d movement results checked", sb.result_count);
    if (sb.fail_count == 0 && sb.moves_due.size() == 0) begin
      $display("sensor_to_mouse_motion: match");
    end else begin
      $display("sensor_to_mouse_motion: mismatch");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/s2m_pkg.sv
rtl/s2m_ctrl.sv
rtl/s2m_dpath.sv
rtl/sensor_to_mouse_motion.sv
tb/tb_sensor_to_mouse_motion.sv
